[hdl/mtep_pkg.sv]
package mtep_pkg;

   localparam int LENGTH_BITS = 28;
   localparam int DELTA_BITS = 28;
   localparam int TEMPO_BITS = 24;

   localparam logic [DELTA_BITS-1:0] DELTA_MAX = {DELTA_BITS{1'b1}};

   // Status and meta type bytes.
   localparam logic [7:0] ST_CHAN_LAST = 8'hEF;
   localparam logic [7:0] ST_ONE_FIRST = 8'hC0;
   localparam logic [7:0] ST_ONE_LAST = 8'hDF;
   localparam logic [7:0] ST_SYSEX = 8'hF0;
   localparam logic [7:0] ST_ESCAPE = 8'hF7;
   localparam logic [7:0] ST_META = 8'hFF;
   localparam logic [7:0] META_TEXT_LAST = 8'h07;
   localparam logic [7:0] META_END = 8'h2F;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_SMPTE = 8'h54;
   localparam logic [7:0] META_TIME_SIG = 8'h58;
   localparam logic [7:0] META_KEY = 8'h59;
   localparam logic [7:0] META_SEQ_SPEC = 8'h7F;

   // Event kinds.
   localparam logic [3:0] KIND_ONE_DATA = 4'd0;
   localparam logic [3:0] KIND_TWO_DATA = 4'd1;
   localparam logic [3:0] KIND_SYSEX = 4'd2;
   localparam logic [3:0] KIND_TEXT = 4'd3;
   localparam logic [3:0] KIND_TEMPO = 4'd4;
   localparam logic [3:0] KIND_SMPTE = 4'd5;
   localparam logic [3:0] KIND_TIME_SIG = 4'd6;
   localparam logic [3:0] KIND_KEY = 4'd7;
   localparam logic [3:0] KIND_OTHER_META = 4'd8;
   localparam logic [3:0] KIND_END = 4'd9;
   localparam logic [3:0] KIND_UNKNOWN = 4'd10;
   localparam logic [3:0] KIND_NO_STATUS = 4'd11;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       track_start;
   } req_item_type;

   typedef struct packed {
      logic [DELTA_BITS-1:0] delta_ticks;
      logic [3:0]            event_kind;
      logic [7:0]            status_value;
      logic [7:0]            data_first;
      logic [7:0]            data_second;
      logic [7:0]            meta_type;
      logic [TEMPO_BITS-1:0] tempo_us;
      logic                  run_last;
      logic                  run_empty;
   } rsp_item_type;

endpackage

[hdl/midi_track_event_parser.sv]
// Channel  Direction  Handshake             Beat
// req      in         req_valid/req_stall   req_item: one track byte, track start flag
// rsp      out        rsp_valid/rsp_stall   rsp_item: one decoded event or payload byte
//
// One track byte is taken every cycle while req_stall is low; its parser update is a single pass of logic.
// A result is registered and appears the cycle after the byte that completes it.
// req_stall is high only while a result is held in the output register under rsp_stall.
// Synchronous reset clears the parser state and empties the output register.
// A byte flagged track_start is parsed against freshly cleared state in its own cycle.
module midi_track_event_parser
   import mtep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   typedef enum logic [8:0] {
      PH_DELTA     = 9'b000000001,
      PH_STATUS    = 9'b000000010,
      PH_CH_FIRST  = 9'b000000100,
      PH_CH_SECOND = 9'b000001000,
      PH_SYSLEN    = 9'b000010000,
      PH_SYSDATA   = 9'b000100000,
      PH_METATYPE  = 9'b001000000,
      PH_METALEN   = 9'b010000000,
      PH_METADATA  = 9'b100000000
   } phase_type;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [DELTA_BITS-1:0]  delta_accum_ff, delta_accum_in, delta_accum_cur;
   logic [DELTA_BITS-1:0]  delta_latched_ff, delta_latched_in, delta_latched_cur;
   logic [2:0]             vlq_seen_ff, vlq_seen_in, vlq_seen_cur;
   logic [7:0]             running_ff, running_in, running_cur;
   logic [7:0]             current_ff, current_in, current_cur;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in, remaining_cur, remaining_dec;
   logic [LENGTH_BITS-1:0] remaining_push;
   logic [7:0]             meta_kind_ff, meta_kind_in, meta_kind_cur;
   logic [TEMPO_BITS-1:0]  captured_ff, captured_in, captured_cur;
   logic                   done_ff, done_in, done_cur;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   logic                   accept;
   logic                   emit;
   rsp_item_type           res;
   logic [7:0]             b;
   logic [3:0]             mclass;
   logic [TEMPO_BITS-1:0]  captured_meta;

   function automatic logic [3:0] meta_class(input logic [7:0] t);
      logic [3:0] k;
      if (t == META_END) k = KIND_END;
      else if (t inside {[8'h00:META_TEXT_LAST], META_SEQ_SPEC}) k = KIND_TEXT;
      else if (t == META_TEMPO) k = KIND_TEMPO;
      else if (t == META_SMPTE) k = KIND_SMPTE;
      else if (t == META_TIME_SIG) k = KIND_TIME_SIG;
      else if (t == META_KEY) k = KIND_KEY;
      else k = KIND_OTHER_META;
      return k;
   endfunction

   function automatic logic one_data(input logic [7:0] st);
      return st inside {[ST_ONE_FIRST:ST_ONE_LAST]};
   endfunction

   // Completes a non-text meta event from the captured payload bytes.
   function automatic rsp_item_type meta_result(input rsp_item_type base,
                                                input logic [3:0] k,
                                                input logic [TEMPO_BITS-1:0] cap,
                                                input logic [7:0] mtype);
      rsp_item_type r;
      r = base;
      r.event_kind = k;
      r.status_value = ST_META;
      r.meta_type = mtype;
      if (k == KIND_TEMPO) r.tempo_us = cap;
      if (k == KIND_TIME_SIG || k == KIND_KEY) begin
         r.data_first = cap[23:16];
         r.data_second = cap[15:8];
      end
      return r;
   endfunction

   assign accept = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign b = req_item.track_byte;

   always_comb begin
      if (req_item.track_start) begin
         phase_cur = PH_DELTA;
         delta_accum_cur = '0;
         delta_latched_cur = '0;
         vlq_seen_cur = '0;
         running_cur = '0;
         current_cur = '0;
         remaining_cur = '0;
         meta_kind_cur = '0;
         captured_cur = '0;
         done_cur = 1'b0;
      end else begin
         phase_cur = phase_ff;
         delta_accum_cur = delta_accum_ff;
         delta_latched_cur = delta_latched_ff;
         vlq_seen_cur = vlq_seen_ff;
         running_cur = running_ff;
         current_cur = current_ff;
         remaining_cur = remaining_ff;
         meta_kind_cur = meta_kind_ff;
         captured_cur = captured_ff;
         done_cur = done_ff;
      end
   end

   always_comb begin
      phase_in = phase_cur;
      delta_accum_in = delta_accum_cur;
      delta_latched_in = delta_latched_cur;
      vlq_seen_in = vlq_seen_cur;
      running_in = running_cur;
      current_in = current_cur;
      remaining_in = remaining_cur;
      meta_kind_in = meta_kind_cur;
      captured_in = captured_cur;
      done_in = done_cur;
      emit = 1'b0;
      res = '0;
      res.delta_ticks = delta_latched_cur;
      mclass = meta_class(meta_kind_cur);
      remaining_dec = (remaining_cur != '0) ? remaining_cur - LENGTH_BITS'(1) : remaining_cur;
      // Saturating seven-bit push of the length accumulator.
      remaining_push = (remaining_cur[LENGTH_BITS-1:LENGTH_BITS-7] != '0) ? {LENGTH_BITS{1'b1}}
                       : {remaining_cur[LENGTH_BITS-8:0], b[6:0]};
      captured_meta = captured_cur;
      case (vlq_seen_cur)
         3'd0:    captured_meta[23:16] = b;
         3'd1:    captured_meta[15:8] = b;
         3'd2:    captured_meta[7:0] = b;
         default: captured_meta = captured_cur;
      endcase

      if (!done_cur) begin
         case (phase_cur)
            PH_DELTA: begin
               delta_accum_in = (delta_accum_cur[DELTA_BITS-1:DELTA_BITS-7] != '0) ? DELTA_MAX
                                : {delta_accum_cur[DELTA_BITS-8:0], b[6:0]};
               if (vlq_seen_cur < 3'd7) vlq_seen_in = vlq_seen_cur + 3'd1;
               if (!b[7]) begin
                  delta_latched_in = delta_accum_in;
                  delta_accum_in = '0;
                  vlq_seen_in = '0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (!b[7]) begin
                  phase_in = PH_DELTA;
                  if (running_cur == '0) begin
                     emit = 1'b1;
                     res.event_kind = KIND_NO_STATUS;
                     res.data_first = b;
                  end else begin
                     current_in = running_cur;
                     if (one_data(running_cur)) begin
                        emit = 1'b1;
                        res.event_kind = KIND_ONE_DATA;
                        res.status_value = running_cur;
                        res.data_first = b;
                     end else begin
                        captured_in = {{(TEMPO_BITS-8){1'b0}}, b};
                        phase_in = PH_CH_SECOND;
                     end
                  end
               end else if (b <= ST_CHAN_LAST) begin
                  running_in = b;
                  current_in = b;
                  phase_in = PH_CH_FIRST;
               end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                  current_in = b;
                  remaining_in = '0;
                  phase_in = PH_SYSLEN;
               end else if (b == ST_META) begin
                  current_in = b;
                  phase_in = PH_METATYPE;
               end else begin
                  phase_in = PH_DELTA;
                  emit = 1'b1;
                  res.event_kind = KIND_UNKNOWN;
                  res.status_value = b;
               end
            end
            PH_CH_FIRST: begin
               if (one_data(current_cur)) begin
                  phase_in = PH_DELTA;
                  emit = 1'b1;
                  res.event_kind = KIND_ONE_DATA;
                  res.status_value = current_cur;
                  res.data_first = b;
               end else begin
                  captured_in = {{(TEMPO_BITS-8){1'b0}}, b};
                  phase_in = PH_CH_SECOND;
               end
            end
            PH_CH_SECOND: begin
               phase_in = PH_DELTA;
               emit = 1'b1;
               res.event_kind = KIND_TWO_DATA;
               res.status_value = current_cur;
               res.data_first = captured_cur[7:0];
               res.data_second = b;
            end
            PH_SYSLEN: begin
               remaining_in = remaining_push;
               if (!b[7]) begin
                  if (remaining_push == '0) begin
                     phase_in = PH_DELTA;
                     emit = 1'b1;
                     res.event_kind = KIND_SYSEX;
                     res.status_value = current_cur;
                     res.run_last = 1'b1;
                     res.run_empty = 1'b1;
                  end else begin
                     phase_in = PH_SYSDATA;
                  end
               end
            end
            PH_SYSDATA: begin
               remaining_in = remaining_dec;
               if (remaining_dec == '0) phase_in = PH_DELTA;
               emit = 1'b1;
               res.event_kind = KIND_SYSEX;
               res.status_value = current_cur;
               res.data_first = b;
               res.run_last = (remaining_dec == '0);
            end
            PH_METATYPE: begin
               meta_kind_in = b;
               captured_in = '0;
               vlq_seen_in = '0;
               phase_in = PH_METALEN;
            end
            PH_METALEN: begin
               remaining_in = {{(LENGTH_BITS-8){1'b0}}, b};
               if (mclass == KIND_END) begin
                  done_in = 1'b1;
                  phase_in = PH_DELTA;
                  emit = 1'b1;
                  res.event_kind = KIND_END;
                  res.status_value = ST_META;
                  res.meta_type = meta_kind_cur;
               end else if (b == '0) begin
                  phase_in = PH_DELTA;
                  emit = 1'b1;
                  if (mclass == KIND_TEXT) begin
                     res.event_kind = KIND_TEXT;
                     res.status_value = ST_META;
                     res.meta_type = meta_kind_cur;
                     res.run_last = 1'b1;
                     res.run_empty = 1'b1;
                  end else begin
                     res = meta_result(res, mclass, captured_cur, meta_kind_cur);
                  end
               end else begin
                  phase_in = PH_METADATA;
               end
            end
            PH_METADATA: begin
               remaining_in = remaining_dec;
               if (mclass == KIND_TEXT) begin
                  if (remaining_dec == '0) phase_in = PH_DELTA;
                  emit = 1'b1;
                  res.event_kind = KIND_TEXT;
                  res.status_value = ST_META;
                  res.data_first = b;
                  res.meta_type = meta_kind_cur;
                  res.run_last = (remaining_dec == '0);
               end else begin
                  // Only the first three payload bytes are kept.
                  if (vlq_seen_cur < 3'd3) begin
                     captured_in = captured_meta;
                     vlq_seen_in = vlq_seen_cur + 3'd1;
                  end
                  if (remaining_dec == '0) begin
                     phase_in = PH_DELTA;
                     emit = 1'b1;
                     res = meta_result(res, mclass, captured_in, meta_kind_cur);
                  end
               end
            end
            default: begin
               phase_in = PH_DELTA;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in = rsp_item_ff;
      if (accept) begin
         rsp_valid_in = emit;
         rsp_item_in = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         delta_accum_ff <= '0;
         delta_latched_ff <= '0;
         vlq_seen_ff <= '0;
         running_ff <= '0;
         current_ff <= '0;
         remaining_ff <= '0;
         meta_kind_ff <= '0;
         captured_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            delta_accum_ff <= delta_accum_in;
            delta_latched_ff <= delta_latched_in;
            vlq_seen_ff <= vlq_seen_in;
            running_ff <= running_in;
            current_ff <= current_in;
            remaining_ff <= remaining_in;
            meta_kind_ff <= meta_kind_in;
            captured_ff <= captured_in;
            done_ff <= done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

[hdl/mtep_checker.sv]
module mtep_checker
   import mtep_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // A result held under stall keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // A track byte held under stall keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("track byte changed while stalled");

   // The input side only waits while the output register is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with a free output register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.run_empty |-> rsp_item.run_last &&
         (rsp_item.event_kind == KIND_SYSEX || rsp_item.event_kind == KIND_TEXT))
      else $error("empty run flag on a result that does not close a run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.event_kind != KIND_TEMPO |-> rsp_item.tempo_us == '0)
      else $error("tempo field set on a non-tempo result");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_item(req_item),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_item(rsp_item)
);
